FILE: design/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg: shared types and constants for the serial loaded bank mapper
// Bus operation codes, result targets, payload structs and mapper state.
// ----------------------------------------------------------------------------
package slbm_pkg;

   // Default address widths of program ROM and pattern memory
   localparam int PRG_ADDR_BITS_DEFAULT = 18;
   localparam int CHR_ADDR_BITS_DEFAULT = 17;

   // Field widths
   localparam int ADDRESS_WIDTH = 16;
   localparam int DATA_WIDTH    = 8;
   localparam int MAPPED_WIDTH  = 18;
   localparam int COUNT_WIDTH   = 5;
   localparam int SERIAL_WIDTH  = 5;
   localparam int BANK_WIDTH    = 4;
   localparam int CSR_IDX_WIDTH = 4;

   // Serial register value with only the end marker set
   localparam logic [SERIAL_WIDTH-1:0] SERIAL_EMPTY = 5'h10;
   // Control reset value: 16 KB program banks, high window fixed
   localparam logic [SERIAL_WIDTH-1:0] CONTROL_RESET = 5'h0C;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRG_BANK_COUNT = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHR_BANK_COUNT = 4'd1;

   // Commit destination, selected by address bits 14..13
   typedef enum logic [1:0] {
      DEST_CONTROL   = 2'd0,
      DEST_CHR_LOW   = 2'd1,
      DEST_CHR_HIGH  = 2'd2,
      DEST_PRG_BANK  = 2'd3
   } dest_type;

   typedef enum logic [1:0] {
      OP_CPU_READ  = 2'd0,
      OP_CPU_WRITE = 2'd1,
      OP_PPU_READ  = 2'd2,
      OP_PPU_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TARGET_NONE        = 2'd0,
      TARGET_PROGRAM_ROM = 2'd1,
      TARGET_PATTERN_ROM = 2'd2,
      TARGET_PATTERN_RAM = 2'd3
   } target_type;

   typedef struct packed {
      op_type                   op;
      logic [ADDRESS_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0]    write_data;
   } req_payload_type;

   typedef struct packed {
      target_type              target;
      logic [MAPPED_WIDTH-1:0] mapped_address;
      logic                    write_enable;
      logic [DATA_WIDTH-1:0]   write_byte;
   } rsp_payload_type;

   // Bank registers and configuration seen by the translation logic
   typedef struct packed {
      logic [SERIAL_WIDTH-1:0] mode_control;
      logic [SERIAL_WIDTH-1:0] pattern_bank_low;
      logic [SERIAL_WIDTH-1:0] pattern_bank_high;
      logic [BANK_WIDTH-1:0]   program_bank;
      logic [COUNT_WIDTH-1:0]  prg_bank_count;
      logic [COUNT_WIDTH-1:0]  chr_bank_count;
   } mapper_state_type;

endpackage

FILE: design/slbm_regs.sv
// ----------------------------------------------------------------------------
// slbm_regs: serial load register, bank registers and configuration
// Takes one CPU write per committed transaction into the five-bit serial
// register and commits the fifth bit to the register picked by the address.
// ----------------------------------------------------------------------------
module slbm_regs
   import slbm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Transaction leaving the input stage this cycle
   input  logic                     commit,
   input  req_payload_type          item,
   // Configuration writes
   input  logic                     csr_write,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]   csr_wdata,
   output mapper_state_type         state
);

   logic [SERIAL_WIDTH-1:0] shift_ff, shift_in;
   logic [SERIAL_WIDTH-1:0] control_ff, control_in;
   logic [SERIAL_WIDTH-1:0] chr_low_ff, chr_low_in;
   logic [SERIAL_WIDTH-1:0] chr_high_ff, chr_high_in;
   logic [BANK_WIDTH-1:0]   prg_bank_ff, prg_bank_in;
   logic [COUNT_WIDTH-1:0]  prg_count_ff, prg_count_in;
   logic [COUNT_WIDTH-1:0]  chr_count_ff, chr_count_in;
   logic [SERIAL_WIDTH-1:0] shifted;
   logic                    reg_write;
   dest_type                dest;

   assign reg_write = commit && (item.op == OP_CPU_WRITE) && item.address[15];
   assign shifted   = {item.write_data[0], shift_ff[SERIAL_WIDTH-1:1]};
   assign dest      = dest_type'(item.address[14:13]);

   // Serial load and commit
   always_comb begin
      shift_in    = shift_ff;
      control_in  = control_ff;
      chr_low_in  = chr_low_ff;
      chr_high_in = chr_high_ff;
      prg_bank_in = prg_bank_ff;
      if (reg_write) begin
         if (item.write_data[7]) begin
            shift_in   = SERIAL_EMPTY;
            control_in = control_ff | CONTROL_RESET;
         end else if (!shift_ff[0]) begin
            shift_in = shifted;
         end else begin
            shift_in = SERIAL_EMPTY;
            case (dest)
               DEST_CONTROL:  control_in  = shifted;
               DEST_CHR_LOW:  chr_low_in  = shifted;
               DEST_CHR_HIGH: chr_high_in = shifted;
               default:       prg_bank_in = shifted[BANK_WIDTH-1:0];
            endcase
         end
      end
   end

   // Configuration registers
   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PRG_BANK_COUNT: prg_count_in = csr_wdata;
            CSR_CHR_BANK_COUNT: chr_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SERIAL_EMPTY;
         control_ff   <= CONTROL_RESET;
         chr_low_ff   <= '0;
         chr_high_ff  <= '0;
         prg_bank_ff  <= '0;
         prg_count_ff <= COUNT_WIDTH'(1);
         chr_count_ff <= '0;
      end else begin
         shift_ff     <= shift_in;
         control_ff   <= control_in;
         chr_low_ff   <= chr_low_in;
         chr_high_ff  <= chr_high_in;
         prg_bank_ff  <= prg_bank_in;
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
      end
   end

   assign state.mode_control      = control_ff;
   assign state.pattern_bank_low  = chr_low_ff;
   assign state.pattern_bank_high = chr_high_ff;
   assign state.program_bank      = prg_bank_ff;
   assign state.prg_bank_count    = prg_count_ff;
   assign state.chr_bank_count    = chr_count_ff;

endmodule

FILE: design/slbm_xlate.sv
// ----------------------------------------------------------------------------
// slbm_xlate: address translation
// Maps one bus transaction to its target memory and byte offset using the
// current bank registers.
// ----------------------------------------------------------------------------
module slbm_xlate
   import slbm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT,
   parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEFAULT
)
(
   input  req_payload_type  item,
   input  mapper_state_type state,
   output rsp_payload_type  result
);

   logic [17:0]              prg_full;
   logic [16:0]              chr_full;
   logic [BANK_WIDTH-1:0]    prg_sel;
   logic [SERIAL_WIDTH-1:0]  chr_sel;
   logic [COUNT_WIDTH-1:0]   last_bank;
   logic [PRG_ADDR_BITS-1:0] prg_off;
   logic [CHR_ADDR_BITS-1:0] chr_off;
   logic [12:0]              ram_off;
   logic                     chr_ram;

   assign last_bank = state.prg_bank_count - COUNT_WIDTH'(1);
   assign chr_ram   = (state.chr_bank_count == '0);
   assign ram_off   = item.address[12:0];

   // Program window: 32 KB, or 16 KB with the low or high half fixed
   always_comb begin
      prg_sel = state.program_bank;
      if (!state.mode_control[3]) begin
         prg_full = {state.program_bank[3:1], item.address[14:0]};
      end else begin
         if (!state.mode_control[2] && !item.address[14]) begin
            prg_sel = '0;
         end else if (state.mode_control[2] && item.address[14]) begin
            prg_sel = last_bank[BANK_WIDTH-1:0];
         end
         prg_full = {prg_sel, item.address[13:0]};
      end
   end

   // Pattern window: one 8 KB bank or two 4 KB banks
   always_comb begin
      chr_sel = item.address[12] ? state.pattern_bank_high : state.pattern_bank_low;
      if (!state.mode_control[4]) begin
         chr_full = {state.pattern_bank_low[4:1], item.address[12:0]};
      end else begin
         chr_full = {chr_sel, item.address[11:0]};
      end
   end

   assign prg_off = prg_full[PRG_ADDR_BITS-1:0];
   assign chr_off = chr_full[CHR_ADDR_BITS-1:0];

   // Result selection by operation
   always_comb begin
      result.target         = TARGET_NONE;
      result.mapped_address = '0;
      result.write_enable   = 1'b0;
      result.write_byte     = '0;
      case (item.op)
         OP_CPU_READ: begin
            if (item.address[15]) begin
               result.target         = TARGET_PROGRAM_ROM;
               result.mapped_address = MAPPED_WIDTH'(prg_off);
            end
         end
         OP_PPU_READ: begin
            if (chr_ram) begin
               result.target         = TARGET_PATTERN_RAM;
               result.mapped_address = MAPPED_WIDTH'(ram_off);
            end else begin
               result.target         = TARGET_PATTERN_ROM;
               result.mapped_address = MAPPED_WIDTH'(chr_off);
            end
         end
         OP_PPU_WRITE: begin
            if (chr_ram) begin
               result.target         = TARGET_PATTERN_RAM;
               result.mapped_address = MAPPED_WIDTH'(ram_off);
               result.write_enable   = 1'b1;
               result.write_byte     = item.write_data;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: design/serial_loaded_bank_mapper.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper: cartridge bank mapper top level
// Input register, bank register file, translation logic, result register.
// ----------------------------------------------------------------------------
// One bus transaction is accepted every clock unless the request side is
// stalled. A transaction lands in the input register, is translated
// against the current bank registers and is written to the result register
// once that register is empty or its result is being taken. The result
// register drives the response port, where the result can be taken while
// the result side is not stalled. While the result side stalls, the block
// holds two transactions and then stalls the request side. A CPU write
// updates the serial register as it moves into the result register, so the
// next transaction already sees the new bank setup. Configuration writes
// are always ready and are meant to be issued only while the block is idle.
module serial_loaded_bank_mapper
   import slbm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT,
   parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   // Configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]   csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   req_payload_type  in_payload_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_payload_ff;
   logic             out_load;
   logic             req_accept;
   mapper_state_type state;
   rsp_payload_type  result;

   // Stage handshake
   assign out_load   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_payload_ff <= req_payload;
      end
      if (out_load) begin
         out_payload_ff <= result;
      end
   end

   slbm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .commit    (out_load),
      .item      (in_payload_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .state     (state)
   );

   slbm_xlate #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS),
      .CHR_ADDR_BITS (CHR_ADDR_BITS)
   ) u_xlate (
      .item   (in_payload_ff),
      .state  (state),
      .result (result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

`ifndef ASSERT_OFF
   // A stalled request always means a transaction is held in the input stage
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input stage");

   // A transaction leaving the input stage shows up as a response
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded transaction missing on response");

   // Write strobe only toward pattern RAM
   a_we_ram: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.write_enable) |->
         (rsp_payload.target == TARGET_PATTERN_RAM))
      else $error("write strobe outside pattern RAM");

   // No target means no offset and no data
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.target == TARGET_NONE)) |->
         (rsp_payload.mapped_address == '0 && rsp_payload.write_byte == '0))
      else $error("nonzero fields on untargeted response");
`endif

endmodule
